// ----- sv/quaternion_nlerp_unit_defines.svh -----
`ifndef QUATERNION_NLERP_UNIT_DEFINES_SVH
`define QUATERNION_NLERP_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define QN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define QN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/qnlerp_pkg.sv -----
package qnlerp_pkg;

  localparam int FRAC_BITS_DEF   = 14;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 64;
  localparam int COMP_W     = 16;
  localparam int BLEND_W    = 17;
  localparam int MAG_W      = 32;
  localparam int SUM_W      = 65;
  localparam int ROOT_W     = 33;
  localparam int DREM_W     = 34;

  localparam logic [BLEND_W-1:0] BLEND_ONE = 17'd65536;
  localparam logic [COMP_W-1:0]  SAT_POS   = 16'h7fff;
  localparam logic [COMP_W-1:0]  SAT_NEG   = 16'h8000;

  // Per-item data that rides along with the sum of squares
  typedef struct packed {
    logic                  zero;
    logic [3:0]            neg;
    logic [3:0][MAG_W-1:0] mag;
  } qnlerp_pay_t;

  // Entry of the queue between front and back
  typedef struct packed {
    qnlerp_pay_t      pay;
    logic [SUM_W-1:0] sumsq;
  } qnlerp_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qnlerp_qreq_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qnlerp_qstat_t;

endpackage

// ----- sv/qnlerp_front.sv -----
module qnlerp_front
  import qnlerp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 q_full,
  output logic                 push,
  output qnlerp_item_t         item
);

  logic                      adv;
  logic [5:1]                v_r;
  logic signed [COMP_W-1:0]  a [4];
  logic signed [COMP_W-1:0]  b [4];
  logic [BLEND_W-1:0]        blend;
  logic [BLEND_W-1:0]        w;
  logic [BLEND_W-1:0]        wc;
  logic signed [31:0]        pab_r [4];
  logic signed [33:0]        paw_r [4];
  logic signed [33:0]        pbw_r [4];
  logic signed [33:0]        dot;
  logic signed [33:0]        r_r   [4];
  logic signed [33:0]        r_nxt [4];
  qnlerp_pay_t               pay3_nxt;
  qnlerp_pay_t               pay3_r;
  qnlerp_pay_t               pay4_r;
  qnlerp_pay_t               pay5_r;
  logic [63:0]               sq_r [4];
  logic [SUM_W-1:0]          sum_r;

  // Advance while the last stage is empty or the queue has room
  assign adv       = !v_r[5] || !q_full;
  assign in_tready = adv;
  assign push      = v_r[5] && !q_full;
  assign item      = '{pay: pay5_r, sumsq: sum_r};

  // Unpack fields and clamp the weight
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = in_tdata[COMP_W*i +: COMP_W];
      b[i] = in_tdata[COMP_W*(4+i) +: COMP_W];
    end
    blend = in_tdata[8*COMP_W +: BLEND_W];
    w     = (blend > BLEND_ONE) ? BLEND_ONE : blend;
    wc    = BLEND_ONE - w;
  end

  // Dot product sign and blended components
  always_comb begin
    dot = 34'(pab_r[0]) + 34'(pab_r[1]) + 34'(pab_r[2]) + 34'(pab_r[3]);
    for (int i = 0; i < 4; i++) begin
      r_nxt[i] = dot[33] ? (paw_r[i] - pbw_r[i]) : (paw_r[i] + pbw_r[i]);
    end
  end

  // Magnitudes, signs and the all-zero mark
  always_comb begin
    pay3_nxt.zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      pay3_nxt.neg[i] = r_r[i][33];
      pay3_nxt.mag[i] = r_r[i][33] ? MAG_W'(-r_r[i]) : MAG_W'(r_r[i]);
      if (r_r[i] != '0) begin
        pay3_nxt.zero = 1'b0;
      end
    end
  end

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:1], in_tvalid};
    end
  end

  // Advance the payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        pab_r[i] <= a[i] * b[i];
        paw_r[i] <= a[i] * $signed({1'b0, wc});
        pbw_r[i] <= b[i] * $signed({1'b0, w});
        r_r[i]   <= r_nxt[i];
        sq_r[i]  <= 64'(pay3_r.mag[i]) * 64'(pay3_r.mag[i]);
      end
      pay3_r <= pay3_nxt;
      pay4_r <= pay3_r;
      pay5_r <= pay4_r;
      sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
    end
  end

endmodule

// ----- sv/qnlerp_queue.sv -----
`include "quaternion_nlerp_unit_defines.svh"

module qnlerp_queue
  import qnlerp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic          clk,
  input  logic          rst_n,
  input  qnlerp_qreq_t  req,
  input  qnlerp_item_t  wr_item,
  output qnlerp_qstat_t stat,
  output qnlerp_item_t  rd_item
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  qnlerp_item_t    mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNTW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_item    = mem_r[rp_r];

  // Wrap pointers and track fill
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (req.push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (req.pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    unique case ({req.push, req.pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store a transaction
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  `QN_ASSERT_IMP(a_no_push_full, req.push, !stat.full, "push into full queue")
  `QN_ASSERT_IMP(a_no_pop_empty, req.pop, !stat.empty, "pop from empty queue")
  `QN_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CNTW'(DEPTH), "queue count out of range")
  `QN_ASSERT_NXT(a_push_fills, req.push && !req.pop, !stat.empty, "pushed item lost")

endmodule

// ----- sv/qnlerp_back.sv -----
module qnlerp_back
  import qnlerp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  qnlerp_qstat_t         qstat,
  input  qnlerp_item_t          head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int SQ_N = ROOT_W;
  localparam int DV_N = FRAC_BITS + 1;
  localparam int QW   = FRAC_BITS + 1;
  localparam int DW   = SUM_W + 2;

  logic adv;

  // Root stages, one result bit each
  logic                sv_r    [1:SQ_N];
  logic [SUM_W-1:0]    srem_r  [1:SQ_N];
  logic [ROOT_W-1:0]   sres_r  [1:SQ_N];
  qnlerp_pay_t         spay_r  [1:SQ_N];

  // Divide stages, one quotient bit each
  logic                dv_r    [1:DV_N];
  logic [DREM_W-1:0]   drem_r  [1:DV_N][4];
  logic [QW-1:0]       dquo_r  [1:DV_N][4];
  logic [ROOT_W-1:0]   droot_r [1:DV_N];
  qnlerp_pay_t         dpay_r  [1:DV_N];

  logic                  ov_r;
  logic [OUT_DATA_W-1:0] od_r, od_nxt;
  logic                  ou_r;

  // Whole back pipeline moves when the output register frees up
  assign adv        = !ov_r || out_tready;
  assign pop        = adv && !qstat.empty;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  for (genvar s = 0; s < SQ_N; s++) begin : g_sq
    localparam int K = SQ_N - 1 - s;
    logic              v_i;
    logic [SUM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] res_i;
    qnlerp_pay_t       pay_i;
    logic [DW-1:0]     d;
    logic [DW-1:0]     diff;
    logic              take;

    if (s == 0) begin : g_head
      assign v_i   = pop;
      assign rem_i = head.sumsq;
      assign res_i = '0;
      assign pay_i = head.pay;
    end else begin : g_mid
      assign v_i   = sv_r[s];
      assign rem_i = srem_r[s];
      assign res_i = sres_r[s];
      assign pay_i = spay_r[s];
    end

    // Try the next root bit against the remainder
    assign d    = (DW'(res_i) << (K + 1)) | (DW'(1) << (2 * K));
    assign take = DW'(rem_i) >= d;
    assign diff = DW'(rem_i) - d;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[s+1] <= 1'b0;
      end else if (adv) begin
        sv_r[s+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        srem_r[s+1] <= take ? diff[SUM_W-1:0] : rem_i;
        sres_r[s+1] <= take ? (res_i | (ROOT_W'(1) << K)) : res_i;
        spay_r[s+1] <= pay_i;
      end
    end
  end

  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    logic              v_i;
    logic [ROOT_W-1:0] root_i;
    qnlerp_pay_t       pay_i;
    logic [DREM_W-1:0] rem_i [4];
    logic [QW-1:0]     quo_i [4];
    logic [3:0]        bit_q;

    if (j == 0) begin : g_first
      assign v_i    = sv_r[SQ_N];
      assign root_i = sres_r[SQ_N];
      assign pay_i  = spay_r[SQ_N];
      for (genvar i = 0; i < 4; i++) begin : g_ln
        assign rem_i[i] = DREM_W'(spay_r[SQ_N].mag[i]);
        assign quo_i[i] = '0;
      end
    end else begin : g_mid
      assign v_i    = dv_r[j];
      assign root_i = droot_r[j];
      assign pay_i  = dpay_r[j];
      for (genvar i = 0; i < 4; i++) begin : g_ln
        assign rem_i[i] = drem_r[j][i] << 1;
        assign quo_i[i] = dquo_r[j][i];
      end
    end

    // Compare and subtract per lane
    for (genvar i = 0; i < 4; i++) begin : g_cmp
      assign bit_q[i] = rem_i[i] >= DREM_W'(root_i);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_r[j+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 4; i++) begin
          drem_r[j+1][i] <= bit_q[i] ? (rem_i[i] - DREM_W'(root_i)) : rem_i[i];
          dquo_r[j+1][i] <= (quo_i[i] << 1) | QW'(bit_q[i]);
        end
        droot_r[j+1] <= root_i;
        dpay_r[j+1]  <= pay_i;
      end
    end
  end

  // Saturate quotients, zero the degenerate case
  always_comb begin
    logic [31:0] q;
    for (int i = 0; i < 4; i++) begin
      q = 32'(dquo_r[DV_N][i]);
      if (dpay_r[DV_N].zero) begin
        od_nxt[COMP_W*i +: COMP_W] = '0;
      end else if (dpay_r[DV_N].neg[i]) begin
        od_nxt[COMP_W*i +: COMP_W] = (q > 32'd32768) ? SAT_NEG : COMP_W'(-q);
      end else begin
        od_nxt[COMP_W*i +: COMP_W] = (q > 32'd32767) ? SAT_POS : q[COMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_r[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      od_r <= od_nxt;
      ou_r <= dpay_r[DV_N].zero;
    end
  end

endmodule

// ----- sv/quaternion_nlerp_unit.sv -----
// Channel | Direction | tdata (low bit up)                       | tuser
// in_     | slave     | q1_x q1_y q1_z q1_w q2_x q2_y q2_z q2_w  | -
//         |           | blend, zero padded to 152 bits           |
// out_    | master    | out_x out_y out_z out_w                  | degenerate
//
// One transaction per cycle in steady state while the output is not stalled. Items
// pass through 5 front stages, the queue, 33 root stages (one bit per stage),
// FRAC_BITS+1 divide stages and the output register.
// Reset clears valid bits, queue pointers and the queue count only; no clearing pass.
// An output stall freezes the back pipeline; the front keeps accepting until the
// queue fills.
module quaternion_nlerp_unit
  import qnlerp_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // q1_x, q1_y, q1_z, q1_w, q2_x, q2_y, q2_z, q2_w, blend, pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_x, out_y, out_z, out_w
  output logic [OUT_DATA_W-1:0] out_tdata,
  // degenerate
  output logic                  out_tuser
);

  qnlerp_qreq_t  qreq;
  qnlerp_qstat_t qstat;
  qnlerp_item_t  wr_item;
  qnlerp_item_t  rd_item;
  logic          push;
  logic          pop;

  assign qreq.push = push;
  assign qreq.pop  = pop;

  qnlerp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (qstat.full),
    .push      (push),
    .item      (wr_item)
  );

  qnlerp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (qreq),
    .wr_item (wr_item),
    .stat    (qstat),
    .rd_item (rd_item)
  );

  qnlerp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head       (rd_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- tb/tb_quaternion_nlerp_checker.sv -----
`timescale 1ns / 100ps

module tb_quaternion_nlerp_checker
  import qnlerp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    logic        degenerate;
    logic [15:0] w;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } nlerp_result_t;

  nlerp_result_t blend_q[$];

  // Integer square root, one bit at a time
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Compute the normalized blend of one input transaction
  function automatic nlerp_result_t predict_nlerp(input logic [IN_DATA_W-1:0] d);
    longint        a [4];
    longint        b [4];
    longint        r [4];
    longint        dot;
    longint        wt;
    longint        wc;
    logic [63:0]   sum;
    logic [63:0]   sq;
    logic [63:0]   mag;
    logic [63:0]   root;
    logic [127:0]  quo;
    logic          carry;
    logic          allzero;
    logic [15:0]   comp [4];
    nlerp_result_t res;
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(d[16*i +: 16]));
      b[i] = longint'($signed(d[64 + 16*i +: 16]));
      dot += a[i] * b[i];
    end
    wt = longint'(d[128 +: BLEND_W]);
    if (wt > 65536) wt = 65536;
    wc = 65536 - wt;
    if (dot < 0) wt = -wt;
    sum = 0; carry = 0; allzero = 1;
    for (int i = 0; i < 4; i++) begin
      r[i] = a[i] * wc + wt * b[i];
      if (r[i] != 0) allzero = 0;
      mag = (r[i] < 0) ? -r[i] : r[i];
      sq  = mag * mag;
      if (sum + sq < sum) carry = 1;
      sum = sum + sq;
    end
    res = '0;
    if (allzero) begin
      res.degenerate = 1'b1;
      return res;
    end
    root = carry ? (64'd1 << 32) : root_floor(sum);
    for (int i = 0; i < 4; i++) begin
      mag = (r[i] < 0) ? -r[i] : r[i];
      quo = ({64'd0, mag} << FRAC_BITS_DEF) / root;
      if (r[i] < 0) comp[i] = (quo > 32768) ? SAT_NEG : 16'(-quo);
      else          comp[i] = (quo > 32767) ? SAT_POS : 16'(quo);
    end
    res.x = comp[0]; res.y = comp[1]; res.z = comp[2]; res.w = comp[3];
    return res;
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    nlerp_result_t exp_r;
    if (!rst_n) begin
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (in_tvalid && in_tready) blend_q.push_back(predict_nlerp(in_tdata));
      if (out_tvalid && out_tready) begin
        if (blend_q.size() == 0) begin
          $error("result transaction with no expectation");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = blend_q.pop_front();
          if (exp_r.x !== out_tdata[15:0] || exp_r.y !== out_tdata[31:16]
              || exp_r.z !== out_tdata[47:32] || exp_r.w !== out_tdata[63:48]
              || exp_r.degenerate !== out_tuser)
            fail_count <= fail_count + 1;
          if (exp_r.x !== out_tdata[15:0])
            $error("out_x expected %h actual %h", exp_r.x, out_tdata[15:0]);
          if (exp_r.y !== out_tdata[31:16])
            $error("out_y expected %h actual %h", exp_r.y, out_tdata[31:16]);
          if (exp_r.z !== out_tdata[47:32])
            $error("out_z expected %h actual %h", exp_r.z, out_tdata[47:32]);
          if (exp_r.w !== out_tdata[63:48])
            $error("out_w expected %h actual %h", exp_r.w, out_tdata[63:48]);
          if (exp_r.degenerate !== out_tuser)
            $error("degenerate expected %b actual %b", exp_r.degenerate, out_tuser);
        end
      end
      // Track how many transactions are still expected
      pending_count <= blend_q.size();
    end
  end

endmodule

// ----- tb/tb_quaternion_nlerp_unit.sv -----
`timescale 1ns / 100ps

module tb_quaternion_nlerp_unit
  import qnlerp_pkg::*;
();

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1500;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  int                    fail_count;
  int                    pending_count;
  int                    idle_cycles;
  bit                    calm;

  quaternion_nlerp_unit DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  tb_quaternion_nlerp_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .pending_count
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Throttle the result side about 26 percent, except in calm stretches
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  // Watchdog on cycles with no accepted transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_quaternion_nlerp_unit: done, errors");
      $finish;
    end
  end

  function automatic logic [15:0] rand_comp(input int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rand_blend();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return BLEND_ONE;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Drive one transaction and hold until accepted
  task automatic send_blend(input logic [15:0] q1 [4], input logic [15:0] q2 [4],
                            input logic [16:0] wt);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    for (int i = 0; i < 4; i++) begin
      d[16*i +: 16]      = q1[i];
      d[64 + 16*i +: 16] = q2[i];
    end
    d[128 +: BLEND_W] = wt;
    while (!calm && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drop_valid();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] q1 [4];
    logic [15:0] q2 [4];
    int          drain;
    calm = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, zero blend result, zero dot, saturated blend
    foreach (q1[i]) begin q1[i] = 16'h8000; q2[i] = 16'h8000; end
    send_blend(q1, q2, 17'd0);
    send_blend(q1, q2, BLEND_ONE);
    send_blend(q1, q2, 17'h1ffff);
    foreach (q1[i]) begin q1[i] = 16'h7fff; q2[i] = 16'h8000; end
    send_blend(q1, q2, 17'd32768);
    send_blend(q1, q2, 17'd0);
    foreach (q1[i]) begin q1[i] = 16'h0000; q2[i] = 16'h0000; end
    send_blend(q1, q2, 17'd40000);
    foreach (q1[i]) begin q1[i] = 16'h4000; q2[i] = 16'h4000; end
    send_blend(q1, q2, 17'd32768);
    q1 = '{16'h4000, 16'h0, 16'h0, 16'h0};
    q2 = '{16'h0, 16'h4000, 16'h0, 16'h0};
    send_blend(q1, q2, 17'd32768);
    send_blend(q1, q2, 17'd65537);
    q2 = '{16'h0, 16'h0, 16'h0, 16'h0};
    send_blend(q1, q2, BLEND_ONE);
    q2 = '{16'hc000, 16'h0, 16'h0, 16'h0};
    send_blend(q1, q2, 17'd32768);
    send_blend(q1, q2, 17'd20000);
    q1 = '{16'h0001, 16'hffff, 16'h0, 16'h0};
    q2 = '{16'h0001, 16'h0001, 16'h0, 16'h0};
    send_blend(q1, q2, 17'd1);
    send_blend(q1, q2, 17'd65535);

    // Hold off until the pipeline drains
    drop_valid();
    while (pending_count != 0) @(posedge clk);

    // Random part with a calm stretch in the middle
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 600 && n < 800);
      for (int i = 0; i < 4; i++) begin
        q1[i] = rand_comp($urandom_range(12));
        q2[i] = rand_comp($urandom_range(12));
      end
      // Occasionally make q2 the negation of q1 to exercise the sign flip on a negative dot
      if ($urandom_range(15) == 0)
        foreach (q2[i]) q2[i] = -q1[i];
      send_blend(q1, q2, rand_blend());
    end
    calm = 0;
    drop_valid();

    drain = 0;
    while (pending_count != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_quaternion_nlerp_unit: done, clean");
    else
      $display("tb_quaternion_nlerp_unit: done, errors");
    $finish;
  end

endmodule
